FILE: design/sd_init_pkg.sv
// Types and constants shared by the SD card SPI-mode initialisation sequencer.
// Holds the input and result word layouts, card type codes and command numbers.
// No dependencies.
package sd_init_pkg;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  resp_r1;
    logic [31:0] resp_extra;
  } in_item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [7:0]  cmd_crc;
    logic        idle_preamble;
    logic        read_extra;
    logic        done_res;
    logic [2:0]  card_type;
    logic        block_addressed;
    logic [7:0]  fail_code;
  } out_item_t;

  // Request kinds
  localparam logic REQ_START = 1'b0;

  // Card type codes
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MMC  = 3'd1;
  localparam logic [2:0] KIND_V1   = 3'd2;
  localparam logic [2:0] KIND_V2   = 3'd3;
  localparam logic [2:0] KIND_V2HC = 3'd4;

  // Command numbers
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_OP   = 6'd1;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_SET_BLEN  = 6'd16;
  localparam logic [5:0] CMD_APP_OP    = 6'd41;
  localparam logic [5:0] CMD_APP_CMD   = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  // Frame constants
  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [7:0]  CRC_DUMMY   = 8'h01;
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01aa;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [7:0]  ECHO_PATTERN = 8'haa;
  localparam logic [7:0]  ECHO_VOLT   = 8'h01;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESET_RETRY = 2'd0;
  localparam logic [1:0] CFG_OP_RETRY    = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEN   = 2'd2;

  localparam logic [7:0]  RESET_RETRY_DEFAULT = 8'd20;
  localparam logic [15:0] OP_RETRY_DEFAULT    = 16'hffff;
  localparam logic [12:0] BLOCK_LEN_DEFAULT   = 13'd512;

endpackage

FILE: design/sd_spi_init_sequencer_top.sv
// SD card SPI-mode initialisation sequencer, command level.
// Depends on sd_init_pkg for word layouts, card codes and command numbers.
//
// Usage: send a start word (req_type 0) to begin; the block answers with the
// first CMD0 frame. Each later input word carries the polled R1 byte (and the
// four trailing bytes after CMD8/CMD58) of the last command, and yields either
// the next command frame or a done word with the card type and fail code.
// A response word arriving while idle or done produces no result.
// Configuration registers (CMD0 retry limit, op-cond poll limit, block length)
// are written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while no word is in flight, which the block itself does not enforce.
// Each word passes the input register, then the result register. Throughput is
// one word per cycle while out_stall is low; the state update is combinational.
// When out_stall is held, the result register holds its word and the input
// register stalls behind it; one word waits in each before in_stall rises.
// Reset (rst_n low, synchronous) empties both registers, returns the sequencer
// to idle and loads the default limits and block length.
module sd_spi_init_sequencer_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sd_init_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sd_init_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_CMD0      = 4'd1;
  localparam logic [3:0] PH_CMD8      = 4'd2;
  localparam logic [3:0] PH_V2_APP    = 4'd3;
  localparam logic [3:0] PH_V2_OP     = 4'd4;
  localparam logic [3:0] PH_CMD58     = 4'd5;
  localparam logic [3:0] PH_PROBE_APP = 4'd6;
  localparam logic [3:0] PH_PROBE_OP  = 4'd7;
  localparam logic [3:0] PH_V1_APP    = 4'd8;
  localparam logic [3:0] PH_V1_OP     = 4'd9;
  localparam logic [3:0] PH_MMC_OP    = 4'd10;
  localparam logic [3:0] PH_CMD16     = 4'd11;
  localparam logic [3:0] PH_DONE      = 4'd12;

  logic [7:0]             reset_retry_r;
  logic [15:0]            op_retry_r;
  logic [12:0]            block_len_r;

  logic                   in_valid_r;
  sd_init_pkg::in_item_t  in_data_r;
  logic                   out_valid_r;
  sd_init_pkg::out_item_t out_data_r;

  logic [3:0]             phase_r, phase_nxt;
  logic [15:0]            try_r, try_nxt;
  logic [2:0]             kind_r, kind_nxt;

  sd_init_pkg::out_item_t res_nxt;
  logic                   has_res;
  logic                   advance;
  logic                   fire;

  function automatic sd_init_pkg::out_item_t make_cmd(
    input logic [5:0] idx, input logic [31:0] arg, input logic [7:0] crc,
    input logic pre, input logic extra);
    sd_init_pkg::out_item_t w;
    w               = '0;
    w.cmd_valid     = 1'b1;
    w.cmd_index     = idx;
    w.cmd_arg       = arg;
    w.cmd_crc       = crc;
    w.idle_preamble = pre;
    w.read_extra    = extra;
    return w;
  endfunction

  function automatic sd_init_pkg::out_item_t make_done(
    input logic [2:0] kind, input logic [7:0] fail);
    sd_init_pkg::out_item_t w;
    w                 = '0;
    w.done_res        = 1'b1;
    w.card_type       = kind;
    w.block_addressed = (kind == sd_init_pkg::KIND_V2HC);
    w.fail_code       = (kind == sd_init_pkg::KIND_NONE) ? fail : 8'd0;
    return w;
  endfunction

  // The result register frees up whenever it is empty or being taken.
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [7:0]  r1;
    logic [31:0] ex;
    r1        = in_data_r.resp_r1;
    ex        = in_data_r.resp_extra;
    res_nxt   = '0;
    has_res   = 1'b1;
    phase_nxt = phase_r;
    try_nxt   = try_r;
    kind_nxt  = kind_r;

    if (in_data_r.req_type == sd_init_pkg::REQ_START) begin
      kind_nxt  = sd_init_pkg::KIND_NONE;
      try_nxt   = 16'd1;
      phase_nxt = PH_CMD0;
      res_nxt   = make_cmd(sd_init_pkg::CMD_GO_IDLE, 32'd0, sd_init_pkg::CRC_CMD0, 1'b1, 1'b0);
    end else begin
      unique case (phase_r) inside
        PH_CMD0: begin
          if (r1 == sd_init_pkg::R1_IDLE) begin
            phase_nxt = PH_CMD8;
            res_nxt   = make_cmd(sd_init_pkg::CMD_SEND_IF, sd_init_pkg::ARG_CMD8,
                                 sd_init_pkg::CRC_CMD8, 1'b0, 1'b1);
          end else if (try_r < {8'd0, reset_retry_r}) begin
            try_nxt = try_r + 16'd1;
            res_nxt = make_cmd(sd_init_pkg::CMD_GO_IDLE, 32'd0, sd_init_pkg::CRC_CMD0,
                               1'b0, 1'b0);
          end else begin
            phase_nxt = PH_DONE;
            kind_nxt  = sd_init_pkg::KIND_NONE;
            res_nxt   = make_done(sd_init_pkg::KIND_NONE, r1);
          end
        end
        PH_CMD8: begin
          if (r1 == sd_init_pkg::R1_IDLE) begin
            if (ex[15:8] == sd_init_pkg::ECHO_VOLT && ex[7:0] == sd_init_pkg::ECHO_PATTERN) begin
              try_nxt   = 16'd1;
              phase_nxt = PH_V2_APP;
              res_nxt   = make_cmd(sd_init_pkg::CMD_APP_CMD, 32'd0, sd_init_pkg::CRC_DUMMY,
                                   1'b0, 1'b0);
            end else begin
              phase_nxt = PH_DONE;
              kind_nxt  = sd_init_pkg::KIND_NONE;
              res_nxt   = make_done(sd_init_pkg::KIND_NONE, r1);
            end
          end else begin
            phase_nxt = PH_PROBE_APP;
            res_nxt   = make_cmd(sd_init_pkg::CMD_APP_CMD, 32'd0, sd_init_pkg::CRC_DUMMY,
                                 1'b0, 1'b0);
          end
        end
        PH_V2_APP: begin
          phase_nxt = PH_V2_OP;
          res_nxt   = make_cmd(sd_init_pkg::CMD_APP_OP, sd_init_pkg::ARG_HCS,
                               sd_init_pkg::CRC_DUMMY, 1'b0, 1'b0);
        end
        PH_PROBE_APP: begin
          phase_nxt = PH_PROBE_OP;
          res_nxt   = make_cmd(sd_init_pkg::CMD_APP_OP, 32'd0, sd_init_pkg::CRC_DUMMY,
                               1'b0, 1'b0);
        end
        PH_V1_APP: begin
          phase_nxt = PH_V1_OP;
          res_nxt   = make_cmd(sd_init_pkg::CMD_APP_OP, 32'd0, sd_init_pkg::CRC_DUMMY,
                               1'b0, 1'b0);
        end
        PH_V2_OP: begin
          if (r1 == sd_init_pkg::R1_READY) begin
            phase_nxt = PH_CMD58;
            res_nxt   = make_cmd(sd_init_pkg::CMD_READ_OCR, 32'd0, sd_init_pkg::CRC_DUMMY,
                                 1'b0, 1'b1);
          end else if (try_r < op_retry_r) begin
            try_nxt   = try_r + 16'd1;
            phase_nxt = PH_V2_APP;
            res_nxt   = make_cmd(sd_init_pkg::CMD_APP_CMD, 32'd0, sd_init_pkg::CRC_DUMMY,
                                 1'b0, 1'b0);
          end else begin
            phase_nxt = PH_DONE;
            kind_nxt  = sd_init_pkg::KIND_NONE;
            res_nxt   = make_done(sd_init_pkg::KIND_NONE, r1);
          end
        end
        PH_CMD58: begin
          phase_nxt = PH_DONE;
          if (r1 == sd_init_pkg::R1_READY) begin
            // The CCS bit of the OCR marks a high capacity card.
            kind_nxt = ex[30] ? sd_init_pkg::KIND_V2HC : sd_init_pkg::KIND_V2;
            res_nxt  = make_done(ex[30] ? sd_init_pkg::KIND_V2HC : sd_init_pkg::KIND_V2,
                                 8'd0);
          end else begin
            kind_nxt = sd_init_pkg::KIND_NONE;
            res_nxt  = make_done(sd_init_pkg::KIND_NONE, r1);
          end
        end
        PH_PROBE_OP: begin
          try_nxt = 16'd1;
          if (r1[7:1] == 7'd0) begin
            kind_nxt  = sd_init_pkg::KIND_V1;
            phase_nxt = PH_V1_APP;
            res_nxt   = make_cmd(sd_init_pkg::CMD_APP_CMD, 32'd0, sd_init_pkg::CRC_DUMMY,
                                 1'b0, 1'b0);
          end else begin
            kind_nxt  = sd_init_pkg::KIND_MMC;
            phase_nxt = PH_MMC_OP;
            res_nxt   = make_cmd(sd_init_pkg::CMD_SEND_OP, 32'd0, sd_init_pkg::CRC_DUMMY,
                                 1'b0, 1'b0);
          end
        end
        PH_V1_OP, PH_MMC_OP: begin
          if (r1 == sd_init_pkg::R1_READY) begin
            phase_nxt = PH_CMD16;
            res_nxt   = make_cmd(sd_init_pkg::CMD_SET_BLEN, {19'd0, block_len_r},
                                 sd_init_pkg::CRC_DUMMY, 1'b0, 1'b0);
          end else if (try_r < op_retry_r) begin
            try_nxt = try_r + 16'd1;
            if (phase_r == PH_V1_OP) begin
              phase_nxt = PH_V1_APP;
              res_nxt   = make_cmd(sd_init_pkg::CMD_APP_CMD, 32'd0, sd_init_pkg::CRC_DUMMY,
                                   1'b0, 1'b0);
            end else begin
              res_nxt = make_cmd(sd_init_pkg::CMD_SEND_OP, 32'd0, sd_init_pkg::CRC_DUMMY,
                                 1'b0, 1'b0);
            end
          end else begin
            phase_nxt = PH_DONE;
            kind_nxt  = sd_init_pkg::KIND_NONE;
            res_nxt   = make_done(sd_init_pkg::KIND_NONE, r1);
          end
        end
        PH_CMD16: begin
          phase_nxt = PH_DONE;
          if (r1 == sd_init_pkg::R1_READY) begin
            res_nxt = make_done(kind_r, 8'd0);
          end else begin
            kind_nxt = sd_init_pkg::KIND_NONE;
            res_nxt  = make_done(sd_init_pkg::KIND_NONE, r1);
          end
        end
        default: begin
          // Idle or done: a stray response word is dropped.
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_retry_r <= sd_init_pkg::RESET_RETRY_DEFAULT;
      op_retry_r    <= sd_init_pkg::OP_RETRY_DEFAULT;
      block_len_r   <= sd_init_pkg::BLOCK_LEN_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sd_init_pkg::CFG_RESET_RETRY: reset_retry_r <= cfg_wdata[7:0];
        sd_init_pkg::CFG_OP_RETRY:    op_retry_r    <= cfg_wdata;
        sd_init_pkg::CFG_BLOCK_LEN:   block_len_r   <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      try_r       <= 16'd0;
      kind_r      <= sd_init_pkg::KIND_NONE;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= fire && has_res;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        try_r   <= try_nxt;
        kind_r  <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res_nxt;
    end
  end

endmodule
